### rtl/core/bmva_pkg.sv
// Shared types and constants for the batched matrix-vector accumulate block.
`default_nettype none

package bmva_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned INDEX_W = 6;
	localparam int unsigned VLEN_W  = 7;

	// Item action codes
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_MAC  = 1'b1;

	localparam logic [VLEN_W-1:0] VLEN_RESET = 7'd64;

	typedef struct packed {
		logic                     action;
		logic [INDEX_W-1:0]       batch_index;
		logic [INDEX_W-1:0]       row_index;
		logic [INDEX_W-1:0]       column_index;
		logic signed [DATA_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic [INDEX_W-1:0]       out_batch;
		logic [INDEX_W-1:0]       out_row;
		logic signed [DATA_W-1:0] row_sum;
	} result_t;

	typedef struct packed {
		logic [VLEN_W-1:0] vector_length;
	} cfg_t;

endpackage

`default_nettype wire

### rtl/core/bmva_chan_if.sv
// Valid/ready channel carrying one payload word per handshake.
`default_nettype none

interface bmva_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/bmva_row_store.sv
// Row-sum memory: clearing sweep after reset, one write port, registered write-first read.
`default_nettype none

module bmva_row_store #(
	parameter int unsigned DEPTH  = 4096,
	parameter int unsigned ADDR_W = 12
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          rd_en,
	input  wire logic [ADDR_W-1:0]             rd_addr,
	output logic      [bmva_pkg::DATA_W-1:0]   rd_data,
	input  wire logic                          wr_en,
	input  wire logic [ADDR_W-1:0]             wr_addr,
	input  wire logic [bmva_pkg::DATA_W-1:0]   wr_data,
	output logic                               busy
);

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

	logic [bmva_pkg::DATA_W-1:0] mem_q [DEPTH];
	logic [bmva_pkg::DATA_W-1:0] rd_q;
	logic                        clr_busy_q;
	logic [ADDR_W-1:0]           clr_addr_q;

	logic                        w_en;
	logic [ADDR_W-1:0]           w_addr;
	logic [bmva_pkg::DATA_W-1:0] w_data;

	// sweep zeros through every entry after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_ADDR) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (clr_busy_q) begin
			w_en   = 1'b1;
			w_addr = clr_addr_q;
			w_data = '0;
		end else begin
			w_en   = wr_en;
			w_addr = wr_addr;
			w_data = wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (w_en) begin
			mem_q[w_addr] <= w_data;
		end
	end

	// same-edge write to the read address wins
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (w_en && (w_addr == rd_addr)) begin
				rd_q <= w_data;
			end else begin
				rd_q <= mem_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_q;
	assign busy    = clr_busy_q;

endmodule

`default_nettype wire

### rtl/core/batched_matrix_vector_accumulate.sv
// Top level of the batched matrix-vector multiply-accumulate block.
// Usage:
//   cfg    : one-word write channel, sets vector_length (columns per row).
//            Written only while the block is idle; always ready.
//   item   : input words. action LOAD writes vector element column_index;
//            action MAC multiplies value by that vector element and adds
//            it into the running dot product (column zero restarts it).
//   result : on the last column of a row with batch/row in range, the
//            row's stored sum gets the dot product added and the new sum
//            is sent out. Other items produce no word.
// Throughput: one item per cycle, sustained unless result backpressure fills the pipeline.
// Path: a MAC word passes vector read, multiply, dot add and row-sum update
//   in turn before its result shows on result.valid.
// Reset: all row sums are cleared by a sweep over all BATCH_COUNT*ROWS_PER_BATCH
//   entries (4096 by default); item.ready stays low until it ends.
//   The vector store is not cleared and must be loaded before use.
// Stalls: the result register holds a word until taken; the pipeline keeps
//   filling its empty stages, and item.ready drops only when every stage
//   holds a word.
`default_nettype none

module batched_matrix_vector_accumulate #(
	parameter int unsigned MAX_VECTOR_LENGTH = 64,
	parameter int unsigned BATCH_COUNT       = 64,
	parameter int unsigned ROWS_PER_BATCH    = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	bmva_chan_if.sink   cfg,
	bmva_chan_if.sink   item,
	bmva_chan_if.source result
);

	localparam int unsigned DW     = bmva_pkg::DATA_W;
	localparam int unsigned IW     = bmva_pkg::INDEX_W;
	localparam int unsigned VEC_AW = (MAX_VECTOR_LENGTH > 1) ? $clog2(MAX_VECTOR_LENGTH) : 1;
	localparam int unsigned SLOTS  = BATCH_COUNT * ROWS_PER_BATCH;
	localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// ---------------- configuration ----------------
	logic [bmva_pkg::VLEN_W-1:0] vlen_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlen_q <= bmva_pkg::VLEN_RESET;
		end else if (cfg.valid) begin
			vlen_q <= cfg.data.vector_length;
		end
	end

	// last column index after clamping the length to 1..MAX
	logic [31:0] vlen_w;
	logic [31:0] eff_len;
	logic [31:0] last_col;

	always_comb begin
		vlen_w = {25'd0, vlen_q};
		if (vlen_q == '0) begin
			eff_len = 32'd1;
		end else if (vlen_w > 32'(MAX_VECTOR_LENGTH)) begin
			eff_len = 32'(MAX_VECTOR_LENGTH);
		end else begin
			eff_len = vlen_w;
		end
		last_col = eff_len - 32'd1;
	end

	// ---------------- pipeline control ----------------
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic emit_s1, emit_s2, emit_s3;
	logic out_free, adv3, take3, adv2, take2, adv1, take1;
	logic clr_busy;
	logic accept, mac_acc, load_acc;

	assign out_free = !out_valid_q || result.ready;
	assign adv3     = v_s3 && (!emit_s3 || out_free);
	assign take3    = !v_s3 || adv3;
	assign adv2     = v_s2 && take3;
	assign take2    = !v_s2 || adv2;
	assign adv1     = v_s1 && take2;
	assign take1    = !v_s1 || adv1;

	assign item.ready = take1 && !clr_busy;
	assign accept     = item.valid && item.ready;
	assign mac_acc    = accept && (item.data.action == bmva_pkg::ACT_MAC);
	assign load_acc   = accept && (item.data.action == bmva_pkg::ACT_LOAD);

	// ---------------- input decode ----------------
	logic [31:0]       col_w, batch_w, row_w;
	logic              col_ok, in_range, is_last;
	logic [VEC_AW-1:0] vec_idx;
	logic [SLOT_W-1:0] slot_in;

	always_comb begin
		col_w    = {26'd0, item.data.column_index};
		batch_w  = {26'd0, item.data.batch_index};
		row_w    = {26'd0, item.data.row_index};
		col_ok   = col_w < 32'(MAX_VECTOR_LENGTH);
		in_range = (batch_w < 32'(BATCH_COUNT)) && (row_w < 32'(ROWS_PER_BATCH));
		is_last  = col_w == last_col;
		vec_idx  = VEC_AW'(col_w);
		slot_in  = SLOT_W'(batch_w * 32'(ROWS_PER_BATCH) + row_w);
	end

	// ---------------- vector store ----------------
	logic [DW-1:0] vec_mem_q [MAX_VECTOR_LENGTH];
	logic [DW-1:0] vec_rd_s1;

	always_ff @(posedge clk) begin
		if (load_acc && col_ok) begin
			vec_mem_q[vec_idx] <= $unsigned(item.data.value);
		end
		if (mac_acc) begin
			vec_rd_s1 <= vec_mem_q[vec_idx];
		end
	end

	// ---------------- stage 1: multiply ----------------
	logic [DW-1:0]     val_s1;
	logic              vec_ok_s1, col0_s1;
	logic [IW-1:0]     batch_s1, row_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [DW-1:0]     prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take1) begin
			v_s1 <= mac_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (mac_acc) begin
			val_s1    <= $unsigned(item.data.value);
			vec_ok_s1 <= col_ok;
			col0_s1   <= item.data.column_index == '0;
			emit_s1   <= is_last && in_range;
			batch_s1  <= item.data.batch_index;
			row_s1    <= item.data.row_index;
			slot_s1   <= slot_in;
		end
	end

	// a column past the store multiplies by zero
	assign prod = vec_ok_s1 ? DW'(val_s1 * vec_rd_s1) : '0;

	// ---------------- stage 2: running dot product ----------------
	logic [DW-1:0]     prod_s2;
	logic              col0_s2;
	logic [IW-1:0]     batch_s2, row_s2;
	logic [SLOT_W-1:0] slot_s2;
	logic [DW-1:0]     dot_q, dot_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (take2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			prod_s2  <= prod;
			col0_s2  <= col0_s1;
			emit_s2  <= emit_s1;
			batch_s2 <= batch_s1;
			row_s2   <= row_s1;
			slot_s2  <= slot_s1;
		end
	end

	assign dot_new = col0_s2 ? prod_s2 : dot_q + prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
		end else if (adv2) begin
			dot_q <= dot_new;
		end
	end

	// ---------------- stage 3: row-sum update ----------------
	logic [DW-1:0]     dot_s3, rs_rd, sum3;
	logic [IW-1:0]     batch_s3, row_s3;
	logic [SLOT_W-1:0] slot_s3;
	logic              rs_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (take3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			dot_s3   <= dot_new;
			emit_s3  <= emit_s2;
			batch_s3 <= batch_s2;
			row_s3   <= row_s2;
			slot_s3  <= slot_s2;
		end
	end

	assign rs_wr = adv3 && emit_s3;
	assign sum3  = rs_rd + dot_s3;

	// read issued as the row enters stage 3; write-first covers the row leaving
	bmva_row_store #(
		.DEPTH  (SLOTS),
		.ADDR_W (SLOT_W)
	) u_row_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (adv2),
		.rd_addr (slot_s2),
		.rd_data (rs_rd),
		.wr_en   (rs_wr),
		.wr_addr (slot_s3),
		.wr_data (sum3),
		.busy    (clr_busy)
	);

	// ---------------- result register ----------------
	bmva_pkg::result_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= rs_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (rs_wr) begin
			out_q.out_batch <= batch_s3;
			out_q.out_row   <= row_s3;
			out_q.row_sum   <= $signed(sum3);
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

`ifndef SYNTHESIS
	// a result word only appears from an emitting row in stage 3
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(v_s3 && emit_s3))
		else $error("result word without an emitting row");

	// vector loads end at acceptance and never occupy the pipeline
	a_load_no_stage: assert property (@(posedge clk) disable iff (!arst_n)
		load_acc |=> !v_s1)
		else $error("vector load entered stage 1");

	// no row-sum update may race the clearing sweep
	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !rs_wr && !v_s1 && !v_s2 && !v_s3)
		else $error("row-sum traffic during clearing sweep");

	// the clearing sweep runs once after reset only
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_busy |=> !clr_busy)
		else $error("clearing sweep restarted");
`endif

endmodule

`default_nettype wire

### bench/batched_matrix_vector_accumulate_test.sv
// Self-checking bench for the batched matrix-vector accumulate block.
`default_nettype none

module batched_matrix_vector_accumulate_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Run limits. The stall limit covers the row-sum clear after reset several
	// times over; nothing else legal keeps every channel quiet for that long.
	localparam int unsigned STALL_LIMIT  = 20000;
	localparam int unsigned DRAIN_CYCLES = 8;	// pipeline is 3 deep
	localparam int unsigned PHASES       = 10;
	localparam int unsigned PHASE_ITEMS  = 150;
	localparam int unsigned STORE_DEPTH  = 64;

	logic clk = 1'b0;
	logic arst_n;

	bmva_chan_if #(.T(bmva_pkg::cfg_t))    cfg_ch ();
	bmva_chan_if #(.T(bmva_pkg::item_t))   item_ch ();
	bmva_chan_if #(.T(bmva_pkg::result_t)) result_ch ();

	batched_matrix_vector_accumulate dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (result_ch)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Shadow state of the block: vector store, running dot product,
	// row sums (indexed {batch,row}) and the vector length register.
	// ---------------------------------------------------------------
	logic [bmva_pkg::DATA_W-1:0] vec_model [STORE_DEPTH];
	logic [bmva_pkg::DATA_W-1:0] sums_model [4096];
	logic [bmva_pkg::DATA_W-1:0] dot_model;
	logic [bmva_pkg::VLEN_W-1:0] model_length;

	// Row sums still to come out of the block, oldest first.
	bmva_pkg::result_t expected_sums [$];

	// Bookkeeping
	int unsigned items_sent   = 0;
	int unsigned sums_checked = 0;
	int unsigned length_writes = 0;
	int unsigned mismatches   = 0;
	int unsigned stall_cycles = 0;
	bit          quiet        = 1'b0;	// no idling on either side while set

	// Directed stimulus: a length write or one item word, with the row sum
	// typed in where it is obvious.
	typedef struct {
		bit                          is_len;
		logic [bmva_pkg::VLEN_W-1:0] len;
		bmva_pkg::item_t             w;
		bit                          typed;
		bmva_pkg::result_t           want;
	} step_t;

	step_t directed_steps [$];

	// Register value -> columns actually in use (0 acts as 1, clamp at 64).
	function automatic int unsigned active_columns(input logic [bmva_pkg::VLEN_W-1:0] len);
		if (len == 0)
			return 1;
		if (len > STORE_DEPTH)
			return STORE_DEPTH;
		return 32'(len);
	endfunction

	// Advances the shadow state by one word; returns 1 and the new row sum
	// when the word closes a row.
	function automatic bit predict_row_sum(input bmva_pkg::item_t w,
			output bmva_pkg::result_t sum);
		logic [bmva_pkg::DATA_W-1:0] prod;
		logic [11:0]                 slot;
		sum = '0;
		if (w.action == bmva_pkg::ACT_LOAD) begin
			vec_model[w.column_index] = w.value;
			return 1'b0;
		end
		prod = w.value * vec_model[w.column_index];
		// column zero restarts the dot product, any other column adds to it
		dot_model = (w.column_index == 0) ? prod : dot_model + prod;
		if (w.column_index != active_columns(model_length) - 1)
			return 1'b0;
		slot = {w.batch_index, w.row_index};
		sums_model[slot] = sums_model[slot] + dot_model;
		sum.out_batch = w.batch_index;
		sum.out_row   = w.row_index;
		sum.row_sum   = sums_model[slot];
		return 1'b1;
	endfunction

	function automatic bmva_pkg::item_t load_word(input logic [5:0] col,
			input logic [bmva_pkg::DATA_W-1:0] v);
		bmva_pkg::item_t w;
		w.action       = bmva_pkg::ACT_LOAD;
		w.batch_index  = 6'($urandom_range(0, 63));	// ignored by loads
		w.row_index    = 6'($urandom_range(0, 63));
		w.column_index = col;
		w.value        = v;
		return w;
	endfunction

	function automatic bmva_pkg::item_t mac_word(input logic [5:0] b, input logic [5:0] r,
			input logic [5:0] col, input logic [bmva_pkg::DATA_W-1:0] v);
		bmva_pkg::item_t w;
		w.action       = bmva_pkg::ACT_MAC;
		w.batch_index  = b;
		w.row_index    = r;
		w.column_index = col;
		w.value        = v;
		return w;
	endfunction

	// Mostly uniform, with the arithmetic corners now and then.
	function automatic logic [bmva_pkg::DATA_W-1:0] rand_value();
		case ($urandom_range(0, 15))
			0: return 32'h0000_0000;
			1: return 32'h0000_0001;
			2: return 32'hFFFF_FFFF;
			3: return 32'h7FFF_FFFF;
			4: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic void add_len(input logic [bmva_pkg::VLEN_W-1:0] len);
		step_t s;
		s = '{is_len: 1'b1, len: len, w: '0, typed: 1'b0, want: '0};
		directed_steps.push_back(s);
	endfunction

	function automatic void add_load(input logic [5:0] col,
			input logic [bmva_pkg::DATA_W-1:0] v);
		step_t s;
		s = '{is_len: 1'b0, len: '0, w: load_word(col, v), typed: 1'b0, want: '0};
		directed_steps.push_back(s);
	endfunction

	function automatic void add_mac(input logic [5:0] b, input logic [5:0] r,
			input logic [5:0] col, input logic [bmva_pkg::DATA_W-1:0] v);
		step_t s;
		s = '{is_len: 1'b0, len: '0, w: mac_word(b, r, col, v), typed: 1'b0, want: '0};
		directed_steps.push_back(s);
	endfunction

	function automatic void add_mac_sum(input logic [5:0] b, input logic [5:0] r,
			input logic [5:0] col, input logic [bmva_pkg::DATA_W-1:0] v,
			input logic [bmva_pkg::DATA_W-1:0] sum);
		step_t s;
		s = '{is_len: 1'b0, len: '0, w: mac_word(b, r, col, v), typed: 1'b1,
			want: '{out_batch: b, out_row: r, row_sum: sum}};
		directed_steps.push_back(s);
	endfunction

	// Sends one item word, with a random gap in front unless quiet. valid is
	// left high after the handshake so back-to-back words need no toggle.
	task automatic send_word(input bmva_pkg::item_t w, input bit typed,
			input bmva_pkg::result_t want);
		bmva_pkg::result_t predicted;
		bit                emits;
		if (!quiet) begin
			while ($urandom_range(0, 99) < 30) begin
				item_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= w;
		do
			@(posedge clk);
		while (!item_ch.ready);
		emits = predict_row_sum(w, predicted);
		if (typed)
			expected_sums.push_back(want);
		else if (emits)
			expected_sums.push_back(predicted);
		items_sent++;
	endtask

	// Stops sending, waits for every pending row sum, then lets words that
	// close no row leave the pipeline as well.
	task automatic drain_sums();
		item_ch.valid <= 1'b0;
		while (expected_sums.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Length register is only touched with the block idle.
	task automatic write_length(input logic [bmva_pkg::VLEN_W-1:0] len);
		drain_sums();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= '{vector_length: len};
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		model_length = len;
		length_writes++;
	endtask

	// ---------------------------------------------------------------
	// Result side: random backpressure, in-order compare per field.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (result_ch.valid && result_ch.ready) begin
			if (expected_sums.size() == 0) begin
				$display("%0t: expected no word, actual batch=%0d row=%0d sum=%0d",
					$time, result_ch.data.out_batch, result_ch.data.out_row,
					result_ch.data.row_sum);
				mismatches++;
			end else begin
				if (result_ch.data.out_batch !== expected_sums[0].out_batch) begin
					$display("%0t: out_batch expected %0d actual %0d", $time,
						expected_sums[0].out_batch, result_ch.data.out_batch);
					mismatches++;
				end
				if (result_ch.data.out_row !== expected_sums[0].out_row) begin
					$display("%0t: out_row expected %0d actual %0d", $time,
						expected_sums[0].out_row, result_ch.data.out_row);
					mismatches++;
				end
				if (result_ch.data.row_sum !== expected_sums[0].row_sum) begin
					$display("%0t: row_sum expected %0d actual %0d", $time,
						expected_sums[0].row_sum, result_ch.data.row_sum);
					mismatches++;
				end
				void'(expected_sums.pop_front());
				sums_checked++;
			end
		end
		result_ch.ready <= quiet || ($urandom_range(0, 99) >= 30);
	end

	// Watchdog: any handshake on any channel counts as progress.
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
		$display("[batched_matrix_vector_accumulate] ERROR");
		$finish;
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin
		int          c;
		int          lo;
		int          hi;
		int          pick;
		int unsigned cols;
		int unsigned phase_start;
		logic [5:0]  b;
		logic [5:0]  r;
		logic [bmva_pkg::VLEN_W-1:0] len;
		bit          paused;
		bmva_pkg::item_t noise;
		logic [bmva_pkg::VLEN_W-1:0] phase_len [PHASES];

		arst_n           = 1'b0;
		item_ch.valid    = 1'b0;
		item_ch.data     = '0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.data      = '0;
		result_ch.ready  = 1'b0;
		foreach (vec_model[i])
			vec_model[i] = '0;
		foreach (sums_model[i])
			sums_model[i] = '0;
		dot_model    = '0;
		model_length = bmva_pkg::VLEN_RESET;
		paused       = 1'b0;
		// register maximum first, full store depth last, zero and other lengths in between
		phase_len = '{7'd127, 7'd1, 7'd2, 7'd64, 7'd3, 7'd0, 7'd16, 7'd5, 7'd33, 7'd64};

		// Directed table. Every MAC column read here was loaded first.
		add_len(7'd1);
		add_load(6'd0, 32'd3);
		add_mac_sum(6'd0, 6'd0, 6'd0, 32'd5, 32'd15);		// sums start at zero
		add_mac_sum(6'd63, 6'd63, 6'd0, 32'hFFFF_FFFF, -32'sd3);	// top batch/row
		add_mac_sum(6'd0, 6'd0, 6'd0, 32'd5, 32'd30);		// accumulates
		add_load(6'd0, 32'h7FFF_FFFF);
		add_mac_sum(6'd1, 6'd2, 6'd0, 32'h7FFF_FFFF, 32'd1);	// max*max wraps to 1
		add_load(6'd0, 32'h8000_0000);
		add_mac_sum(6'd2, 6'd1, 6'd0, 32'hFFFF_FFFF, 32'h8000_0000);
		add_mac_sum(6'd2, 6'd1, 6'd0, 32'h8000_0000, 32'h8000_0000);	// min*min -> 0
		add_len(7'd0);						// acts as one column
		add_load(6'd0, 32'd7);
		add_mac_sum(6'd3, 6'd3, 6'd0, 32'd2, 32'd14);
		add_len(7'd3);
		add_load(6'd1, 32'd2);
		add_load(6'd2, -32'sd4);
		add_mac(6'd5, 6'd7, 6'd0, 32'd1);
		add_mac(6'd5, 6'd7, 6'd1, 32'd10);
		add_mac_sum(6'd5, 6'd7, 6'd2, 32'd1, 32'd23);		// 7 + 20 - 4
		add_load(6'd5, 32'd9);
		add_mac(6'd5, 6'd7, 6'd5, 32'd1);			// past last column: silent
		add_mac(6'd5, 6'd7, 6'd1, 32'd1);			// no restart
		add_mac(6'd5, 6'd7, 6'd2, 32'd0);			// closes the row

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_steps[i]) begin
			if (directed_steps[i].is_len)
				write_length(directed_steps[i].len);
			else
				send_word(directed_steps[i].w, directed_steps[i].typed,
					directed_steps[i].want);
		end

		// Fill the whole vector store so any column may be read from here on.
		for (c = 0; c < STORE_DEPTH; c++)
			send_word(load_word(6'(c), rand_value()), 1'b0, '0);

		for (int phase = 0; phase < PHASES; phase++) begin
			len = (phase == 8) ? 7'($urandom_range(1, 64)) : phase_len[phase];
			write_length(len);
			cols  = active_columns(len);
			quiet = (phase == 4);		// one long stretch without gaps
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				// once, hold the sender until every row sum is out
				if (phase == 6 && !paused && items_sent - phase_start >= PHASE_ITEMS / 2) begin
					drain_sums();
					paused = 1'b1;
				end
				pick = $urandom_range(0, 99);
				if (pick < 15) begin
					// vector reload over a random span
					lo = $urandom_range(0, 63);
					hi = $urandom_range(lo, 63);
					for (c = lo; c <= hi; c++)
						send_word(load_word(6'(c), rand_value()), 1'b0, '0);
				end else if (pick < 80) begin
					// full row; hot rows half the time so sums build up
					if ($urandom_range(0, 1)) begin
						b = 6'($urandom_range(0, 1));
						r = 6'($urandom_range(0, 1));
					end else begin
						b = 6'($urandom_range(0, 63));
						r = 6'($urandom_range(0, 63));
					end
					for (c = 0; c < cols; c++)
						send_word(mac_word(b, r, 6'(c), rand_value()), 1'b0, '0);
				end else if (pick < 90) begin
					// broken row: odd start and end, may run past the last column
					b  = 6'($urandom_range(0, 63));
					r  = 6'($urandom_range(0, 63));
					lo = $urandom_range(0, 63);
					hi = $urandom_range(lo, 63);
					for (c = lo; c <= hi; c++)
						send_word(mac_word(b, r, 6'(c), rand_value()), 1'b0, '0);
				end else begin
					noise.action       = 1'($urandom_range(0, 1));
					noise.batch_index  = 6'($urandom_range(0, 63));
					noise.row_index    = 6'($urandom_range(0, 63));
					noise.column_index = 6'($urandom_range(0, 63));
					noise.value        = $urandom;
					send_word(noise, 1'b0, '0);
				end
			end
		end
		quiet = 1'b0;

		drain_sums();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d item words over %0d length settings (0, 1..64, 127 included),",
			items_sent, length_writes);
		$display("checked %0d row sums under random gaps and result backpressure.",
			sums_checked);
		if (mismatches == 0)
			$display("[batched_matrix_vector_accumulate] OK");
		else
			$display("[batched_matrix_vector_accumulate] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
